// ===== hdl/mic_pkg.sv =====
// shared types and constants for the magnetometer iron calibration block
`default_nettype none
package mic_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int CNT_W         = 16;
  localparam int FACTOR_W      = 20;
  localparam int AXES          = 3;
  localparam int HALF_W        = 15;  // (max-min)/2 never exceeds 32767
  localparam int SUM_W         = 17;  // sum of three half-spans
  localparam int FRAC_BITS_DEF = 12;

  localparam logic signed [SAMPLE_W-1:0] TRACK_MAX_RESET = -16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] TRACK_MIN_RESET = 16'sd32767;
  localparam logic [CNT_W-1:0]           SAMPLE_COUNT_RESET = 16'd3000;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_PREP,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  sum;
    logic [HALF_W-1:0] half;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] factor;
  } div_res_t;

endpackage
`default_nettype wire

// ===== hdl/mic_serdiv.sv =====
// bit-serial restoring divider: (sum << frac) / (3 * half), saturated to factor width
`default_nettype none
module mic_serdiv
  import mic_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_res_t      res
);

  localparam int QW     = SUM_W + FRAC_BITS;
  localparam int DIVR_W = HALF_W + 2;
  localparam int CW     = $clog2(QW + 1);

  logic [QW-1:0]     q_r, q_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] divr_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r;
  logic              done_r;

  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_diff;
  logic              ge;

  // one quotient bit per cycle, dividend bits shift out as quotient bits shift in
  always_comb begin
    rem_sh   = {rem_r, q_r[QW-1]};
    rem_diff = rem_sh - {1'b0, divr_r};
    ge       = rem_sh >= {1'b0, divr_r};
    rem_nxt  = ge ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
    q_nxt    = {q_r[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= {req.sum, {FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        divr_r <= {2'b00, req.half} + {1'b0, req.half, 1'b0};
        cnt_r  <= CW'(QW);
        run_r  <= 1'b1;
      end else if (run_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res.done   = done_r;
    res.factor = (|q_r[QW-1:FACTOR_W]) ? {FACTOR_W{1'b1}} : q_r[FACTOR_W-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/magnetometer_iron_calibration.sv =====
// top level: min/max tracking per axis, hard-iron bias and soft-iron factor per run
`default_nettype none
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_raw_x, in_raw_y, in_raw_z
// out      output     out_valid/out_stall  out_bias_*, out_factor_*, out_zero_span_mask
// cfg      input      cfg_wr_en            cfg_wr_data (sample count)
//
// a sample transfer does the min/max compare for every axis at once
// the sample that ends a run is followed by a prep state and one pass of the shared
//   bit-serial divider per axis, one axis at a time
// rst_n is synchronous; it clears the trackers, the counter and the result valid
// in_stall is high while a run is being finished, and also while an untaken result
//   waits and the next sample would end a new run
// out_stall only holds the result register; samples that do not end a run keep flowing
//
module magnetometer_iron_calibration
  import mic_pkg::*;
#(
  parameter int FACTOR_FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // sample input
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_raw_x,
  input  wire logic signed [SAMPLE_W-1:0] in_raw_y,
  input  wire logic signed [SAMPLE_W-1:0] in_raw_z,
  // result output
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      out_bias_x,
  output logic signed [SAMPLE_W-1:0]      out_bias_y,
  output logic signed [SAMPLE_W-1:0]      out_bias_z,
  output logic [FACTOR_W-1:0]             out_factor_x,
  output logic [FACTOR_W-1:0]             out_factor_y,
  output logic [FACTOR_W-1:0]             out_factor_z,
  output logic [AXES-1:0]                 out_zero_span_mask,
  // configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [CNT_W-1:0]           cfg_wr_data
);

  state_t state_r, state_nxt;

  // trackers and run counter
  logic signed [SAMPLE_W-1:0] max_r [AXES];
  logic signed [SAMPLE_W-1:0] min_r [AXES];
  logic [CNT_W-1:0]           seen_r;
  logic [CNT_W-1:0]           count_r;

  // per-run intermediate values
  logic [HALF_W-1:0]          half_r [AXES];
  logic [SUM_W-1:0]           sum_r;
  logic [1:0]                 ax_r;
  logic                       start_r;

  // result register
  logic signed [SAMPLE_W-1:0] bias_r [AXES];
  logic [FACTOR_W-1:0]        fac_r  [AXES];
  logic [AXES-1:0]            mask_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W-1:0] raw [AXES];
  logic [CNT_W-1:0]           seen_inc;
  logic [CNT_W-1:0]           target;
  logic                       run_ends;
  logic                       in_xfer;
  logic                       out_xfer;
  logic                       prep;

  logic signed [SAMPLE_W:0]   pair_sum  [AXES];
  logic signed [SAMPLE_W:0]   pair_rnd  [AXES];
  logic signed [SAMPLE_W:0]   pair_diff [AXES];
  logic [HALF_W-1:0]          half_c    [AXES];
  logic signed [SAMPLE_W-1:0] bias_c    [AXES];

  div_req_t div_req;
  div_res_t div_res;

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  // a zero count behaves like one; a wrapped counter always ends the run
  assign seen_inc = seen_r + CNT_W'(1);
  assign target   = (count_r == '0) ? CNT_W'(1) : count_r;
  assign run_ends = (seen_inc >= target) || (seen_inc == '0);

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // bias rounds toward zero, half-span is never negative after one sample
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      pair_sum[i]  = {max_r[i][SAMPLE_W-1], max_r[i]} + {min_r[i][SAMPLE_W-1], min_r[i]};
      pair_rnd[i]  = pair_sum[i] + {{SAMPLE_W{1'b0}}, pair_sum[i][SAMPLE_W]};
      bias_c[i]    = pair_rnd[i][SAMPLE_W:1];
      pair_diff[i] = {max_r[i][SAMPLE_W-1], max_r[i]} - {min_r[i][SAMPLE_W-1], min_r[i]};
      half_c[i]    = pair_diff[i][SAMPLE_W] ? '0 : pair_diff[i][HALF_W:1];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: if (in_xfer && run_ends) state_nxt = ST_PREP;
      ST_PREP:    state_nxt = ST_DIV;
      ST_DIV:     if (div_res.done && ax_r == 2'd2) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    prep     = 1'b0;
    unique case (state_r)
      ST_COLLECT: in_stall = out_valid_r && run_ends;
      ST_PREP:    prep     = 1'b1;
      ST_DIV:     in_stall = 1'b1;
      default:    in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      seen_r      <= '0;
      count_r     <= SAMPLE_COUNT_RESET;
      ax_r        <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        max_r[i] <= TRACK_MAX_RESET;
        min_r[i] <= TRACK_MIN_RESET;
      end
    end else begin
      state_r <= state_nxt;
      start_r <= 1'b0;

      if (cfg_wr_en) count_r <= cfg_wr_data;

      if (in_xfer) begin
        seen_r <= seen_inc;
        for (int i = 0; i < AXES; i++) begin
          if (raw[i] > max_r[i]) max_r[i] <= raw[i];
          if (raw[i] < min_r[i]) min_r[i] <= raw[i];
        end
      end

      // while halves and biases latch, clear the run counter, start the x division and reset the trackers
      if (prep) begin
        seen_r  <= '0;
        ax_r    <= '0;
        start_r <= 1'b1;
        for (int i = 0; i < AXES; i++) begin
          max_r[i] <= TRACK_MAX_RESET;
          min_r[i] <= TRACK_MIN_RESET;
        end
      end

      // one divider pass per axis, x then y then z; a taken result drops the valid
      if (state_r == ST_DIV && div_res.done) begin
        if (ax_r == 2'd2) begin
          out_valid_r <= 1'b1;
        end else begin
          ax_r    <= ax_r + 2'd1;
          start_r <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (prep) begin
      sum_r <= SUM_W'({2'b00, half_c[0]}) + SUM_W'({2'b00, half_c[1]})
             + SUM_W'({2'b00, half_c[2]});
      for (int i = 0; i < AXES; i++) begin
        half_r[i] <= half_c[i];
        bias_r[i] <= bias_c[i];
        mask_r[i] <= (half_c[i] == '0);
      end
    end
    // a zero half-span divides by zero, which the divider already saturates
    if (state_r == ST_DIV && div_res.done) fac_r[ax_r] <= div_res.factor;
  end

  assign div_req.start = start_r;
  assign div_req.sum   = sum_r;
  assign div_req.half  = half_r[ax_r];

  mic_serdiv #(
    .FRAC_BITS(FACTOR_FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .res  (div_res)
  );

  assign out_valid          = out_valid_r;
  assign out_bias_x         = bias_r[0];
  assign out_bias_y         = bias_r[1];
  assign out_bias_z         = bias_r[2];
  assign out_factor_x       = fac_r[0];
  assign out_factor_y       = fac_r[1];
  assign out_factor_z       = fac_r[2];
  assign out_zero_span_mask = mask_r;

endmodule
`default_nettype wire

// ===== hdl/mic_checker.sv =====
// port-level checker for the magnetometer iron calibration block, with its bind
`default_nettype none
module mic_checker
  import mic_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic signed [SAMPLE_W-1:0] in_raw_x,
  input wire logic signed [SAMPLE_W-1:0] in_raw_y,
  input wire logic signed [SAMPLE_W-1:0] in_raw_z,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic signed [SAMPLE_W-1:0] out_bias_x,
  input wire logic signed [SAMPLE_W-1:0] out_bias_y,
  input wire logic signed [SAMPLE_W-1:0] out_bias_z,
  input wire logic [FACTOR_W-1:0]        out_factor_x,
  input wire logic [FACTOR_W-1:0]        out_factor_y,
  input wire logic [FACTOR_W-1:0]        out_factor_z,
  input wire logic [AXES-1:0]            out_zero_span_mask,
  input wire logic                       cfg_wr_en,
  input wire logic [CNT_W-1:0]           cfg_wr_data
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bias_x) && $stable(out_bias_y)
      && $stable(out_bias_z) && $stable(out_factor_x) && $stable(out_factor_y)
      && $stable(out_factor_z) && $stable(out_zero_span_mask))
    else $error("result changed while stalled");

  // a held sample keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_raw_x) && $stable(in_raw_y)
      && $stable(in_raw_z))
    else $error("sample changed while stalled");

  // a taken result is not repeated: results never come back to back
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated after transfer");

  // a flagged zero span always comes with a saturated factor
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_zero_span_mask[0] || out_factor_x == {FACTOR_W{1'b1}})
      && (!out_zero_span_mask[1] || out_factor_y == {FACTOR_W{1'b1}})
      && (!out_zero_span_mask[2] || out_factor_z == {FACTOR_W{1'b1}}))
    else $error("zero span without saturated factor");

  // synchronous reset drops any pending result
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (.*);
`default_nettype wire
